/* design/dpd_pkg.sv */
// Shared types and character codes for the debug packet deframer.
// No dependencies; used by dpd_step and debug_packet_deframer.
`default_nettype none

package dpd_pkg;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Offset taken off the run count character.
   localparam logic [7:0] RUN_BIAS = 8'd29;

   typedef struct packed {
      logic       emit;
      logic [7:0] payload_char;
      logic [7:0] repeat_count;
      logic       field_end;
      logic       packet_end;
      logic       checksum_ok;
   } result_type;

endpackage

`default_nettype wire

/* design/dpd_step.sv */
// Packet parsing state and the per-byte decode of the deframer.
// Depends on dpd_pkg for character codes and the result struct.
`default_nettype none

module dpd_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   output dpd_pkg::result_type     result
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PAYLOAD = 3'd1,
      PH_COUNT   = 3'd2,
      PH_HI      = 3'd3,
      PH_LO      = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       hex_error_ff, hex_error_in;
   logic [4:0] hex;
   logic [7:0] sum_next;

   // Returns {digit is valid, digit value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= dpd_pkg::CHAR_ZERO && c <= dpd_pkg::CHAR_NINE) begin
         d = c - dpd_pkg::CHAR_ZERO;
         return {1'b1, d[3:0]};
      end else if (c >= dpd_pkg::CHAR_LOWER_A && c <= dpd_pkg::CHAR_LOWER_F) begin
         d = c - dpd_pkg::CHAR_LOWER_A + 8'd10;
         return {1'b1, d[3:0]};
      end else if (c >= dpd_pkg::CHAR_UPPER_A && c <= dpd_pkg::CHAR_UPPER_F) begin
         d = c - dpd_pkg::CHAR_UPPER_A + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   assign hex      = hex_digit(rx_byte);
   assign sum_next = sum_ff + rx_byte;

   always_comb begin
      phase_in       = phase_ff;
      sum_in         = sum_ff;
      held_char_in   = held_char_ff;
      held_valid_in  = held_valid_ff;
      high_nibble_in = high_nibble_ff;
      hex_error_in   = hex_error_ff;
      result         = '0;
      case (phase_ff)
         PH_PAYLOAD, PH_COUNT: begin
            if (rx_byte == dpd_pkg::CHAR_DOLLAR) begin
               phase_in      = PH_PAYLOAD;
               sum_in        = 8'd0;
               held_char_in  = 8'd0;
               held_valid_in = 1'b0;
            end else if (rx_byte == dpd_pkg::CHAR_HASH) begin
               phase_in         = PH_HI;
               result.emit      = 1'b1;
               result.field_end = 1'b1;
            end else if (phase_ff == PH_COUNT) begin
               sum_in   = sum_next;
               phase_in = PH_PAYLOAD;
               if (held_valid_ff && rx_byte > dpd_pkg::RUN_BIAS) begin
                  result.emit         = 1'b1;
                  result.payload_char = held_char_ff;
                  result.repeat_count = rx_byte - dpd_pkg::RUN_BIAS;
               end
            end else begin
               sum_in = sum_next;
               if (rx_byte inside {dpd_pkg::CHAR_COMMA, dpd_pkg::CHAR_SEMI,
                                   dpd_pkg::CHAR_COLON}) begin
                  // A delimiter drops the held character so runs stay in a field.
                  held_char_in     = 8'd0;
                  held_valid_in    = 1'b0;
                  result.emit      = 1'b1;
                  result.field_end = 1'b1;
               end else if (rx_byte == dpd_pkg::CHAR_STAR) begin
                  phase_in = PH_COUNT;
               end else begin
                  held_char_in        = rx_byte;
                  held_valid_in       = 1'b1;
                  result.emit         = 1'b1;
                  result.payload_char = rx_byte;
                  result.repeat_count = 8'd1;
               end
            end
         end
         PH_HI: begin
            hex_error_in   = !hex[4];
            high_nibble_in = hex[3:0];
            phase_in       = PH_LO;
         end
         PH_LO: begin
            phase_in          = PH_IDLE;
            result.emit       = 1'b1;
            result.packet_end = 1'b1;
            result.checksum_ok = hex[4] && !hex_error_ff &&
                                 ({high_nibble_ff, hex[3:0]} == sum_ff);
         end
         default: begin
            // Idle and unused codes wait for a start marker.
            phase_in = PH_IDLE;
            if (rx_byte == dpd_pkg::CHAR_DOLLAR) begin
               phase_in      = PH_PAYLOAD;
               sum_in        = 8'd0;
               held_char_in  = 8'd0;
               held_valid_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         sum_ff         <= 8'd0;
         held_char_ff   <= 8'd0;
         held_valid_ff  <= 1'b0;
         high_nibble_ff <= 4'd0;
         hex_error_ff   <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         sum_ff         <= sum_in;
         held_char_ff   <= held_char_in;
         held_valid_ff  <= held_valid_in;
         high_nibble_ff <= high_nibble_in;
         hex_error_ff   <= hex_error_in;
      end
   end

endmodule

`default_nettype wire

/* design/debug_packet_deframer.sv */
// Takes the received byte stream of "$payload#hh" debug packets, one byte per transfer,
// and gives at most one result per byte: a decoded character with its repeat count, a
// field or payload end, or the checksum verdict on the second checksum digit. Bytes
// outside a packet give no result. A byte passes an input register and the parsing
// logic in dpd_step before its result lands in the output register, from which it is
// offered. One byte can be taken in every cycle while the output side does not stall.
// While a result waits under rsp_stall, a byte in the input register stays there and
// req_stall is raised.
// Depends on dpd_pkg and dpd_step.
`default_nettype none

module debug_packet_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_payload_char,
   output      logic [7:0] rsp_repeat_count,
   output      logic       rsp_field_end,
   output      logic       rsp_packet_end,
   output      logic       rsp_checksum_ok
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   dpd_pkg::result_type rsp_ff;
   dpd_pkg::result_type result;
   logic                out_free;
   logic                advance;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !out_free);

   assign rsp_valid_in = (advance && result.emit) || (rsp_valid_ff && !out_free);

   dpd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_char = rsp_ff.payload_char;
   assign rsp_repeat_count = rsp_ff.repeat_count;
   assign rsp_field_end    = rsp_ff.field_end;
   assign rsp_packet_end   = rsp_ff.packet_end;
   assign rsp_checksum_ok  = rsp_ff.checksum_ok;

endmodule

`default_nettype wire

/* design/dpd_checker.sv */
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends only on the ports of debug_packet_deframer.
`default_nettype none

module dpd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_payload_char,
   input wire logic [7:0] rsp_repeat_count,
   input wire logic       rsp_field_end,
   input wire logic       rsp_packet_end,
   input wire logic       rsp_checksum_ok
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A character result carries no end flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_count != 8'd0 |-> !rsp_field_end && !rsp_packet_end)
      else $error("character transfer also flags an end");

   // Without a character, the character field reads zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_count == 8'd0 |-> rsp_payload_char == 8'd0)
      else $error("stray character on an empty transfer");

   // The verdict appears only with a packet end, and every result means something.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_packet_end || !rsp_checksum_ok) &&
                    (rsp_repeat_count != 8'd0 || rsp_field_end || rsp_packet_end))
      else $error("result transfer carries no meaning or a misplaced verdict");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload_char (rsp_payload_char),
   .rsp_repeat_count (rsp_repeat_count),
   .rsp_field_end    (rsp_field_end),
   .rsp_packet_end   (rsp_packet_end),
   .rsp_checksum_ok  (rsp_checksum_ok)
);

`default_nettype wire

/* verif/tb_debug_packet_deframer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for debug_packet_deframer: directed and random "$payload#hh" byte
// streams, checked transfer by transfer against a packet parser kept inside the bench.
// Depends on dpd_pkg and the deframer RTL.

module tb_debug_packet_deframer;

   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 60;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_PAYLOAD, SCAN_COUNT, SCAN_CK_HI, SCAN_CK_LO
   } scan_phase_type;

   typedef enum int {CK_GOOD, CK_WRONG, CK_BADHEX} ck_mode_type;

   typedef struct packed {
      logic [7:0] payload_char;
      logic [7:0] repeat_count;
      logic       field_end;
      logic       packet_end;
      logic       checksum_ok;
   } deframed_type;

   typedef logic [7:0] byte_queue_type[$];

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_payload_char;
   logic [7:0] rsp_repeat_count;
   logic       rsp_field_end;
   logic       rsp_packet_end;
   logic       rsp_checksum_ok;

   // Parser state of the bench's own packet decoder.
   scan_phase_type scan_phase = SCAN_IDLE;
   logic [7:0]     frame_sum  = 8'h00;
   logic [7:0]     held_char  = 8'h00;
   logic           held_ok    = 1'b0;
   logic [3:0]     hi_nibble  = 4'h0;
   logic           digit_bad  = 1'b0;

   byte_queue_type rx_backlog;
   deframed_type   decoded_due[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_seq      = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   bit  byte_taken    = 1'b0;
   int  quiet_cycles  = 0;
   int  queued_bytes  = 0;
   int  error_count   = 0;
   int  bytes_taken   = 0;
   int  results_seen  = 0;
   int  ack_count     = 0;
   int  nak_count     = 0;
   int  run_count     = 0;

   debug_packet_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_char (rsp_payload_char),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_field_end    (rsp_field_end),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_checksum_ok  (rsp_checksum_ok)
   );

   always #1 clock = ~clock;

   // Returns {valid, nibble} for one checksum character.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= dpd_pkg::CHAR_ZERO && c <= dpd_pkg::CHAR_NINE)
         return {1'b1, 4'(c - dpd_pkg::CHAR_ZERO)};
      if (c >= dpd_pkg::CHAR_LOWER_A && c <= dpd_pkg::CHAR_LOWER_F)
         return {1'b1, 4'(c - dpd_pkg::CHAR_LOWER_A + 8'd10)};
      if (c >= dpd_pkg::CHAR_UPPER_A && c <= dpd_pkg::CHAR_UPPER_F)
         return {1'b1, 4'(c - dpd_pkg::CHAR_UPPER_A + 8'd10)};
      return 5'b0_0000;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return dpd_pkg::CHAR_ZERO + {4'h0, n};
      return (upper ? dpd_pkg::CHAR_UPPER_A : dpd_pkg::CHAR_LOWER_A) + {4'h0, n} - 8'd10;
   endfunction

   function automatic bit is_delimiter(input logic [7:0] c);
      return c == dpd_pkg::CHAR_COMMA || c == dpd_pkg::CHAR_SEMI ||
             c == dpd_pkg::CHAR_COLON;
   endfunction

   // Advances the decoder by one accepted byte and queues the result it causes, if any.
   function automatic void parse_rx_byte(input logic [7:0] c);
      logic [4:0]   d;
      deframed_type r;
      r = '0;
      if (scan_phase == SCAN_CK_HI) begin
         d = hex_digit(c);
         digit_bad = !d[4];
         hi_nibble = d[3:0];
         scan_phase = SCAN_CK_LO;
      end else if (scan_phase == SCAN_CK_LO) begin
         d = hex_digit(c);
         r.packet_end = 1'b1;
         r.checksum_ok = d[4] && !digit_bad && {hi_nibble, d[3:0]} == frame_sum;
         scan_phase = SCAN_IDLE;
         decoded_due.push_back(r);
      end else if (c == dpd_pkg::CHAR_DOLLAR) begin
         // A start marker opens a packet from idle and restarts one in its payload or count.
         scan_phase = SCAN_PAYLOAD;
         frame_sum = 8'h00;
         held_char = 8'h00;
         held_ok = 1'b0;
      end else if (scan_phase == SCAN_PAYLOAD || scan_phase == SCAN_COUNT) begin
         if (c == dpd_pkg::CHAR_HASH) begin
            scan_phase = SCAN_CK_HI;
            r.field_end = 1'b1;
            decoded_due.push_back(r);
         end else begin
            frame_sum = frame_sum + c;
            if (scan_phase == SCAN_COUNT) begin
               scan_phase = SCAN_PAYLOAD;
               if (held_ok && c > dpd_pkg::RUN_BIAS) begin
                  r.payload_char = held_char;
                  r.repeat_count = c - dpd_pkg::RUN_BIAS;
                  decoded_due.push_back(r);
               end
            end else if (is_delimiter(c)) begin
               held_char = 8'h00;
               held_ok = 1'b0;
               r.field_end = 1'b1;
               decoded_due.push_back(r);
            end else if (c == dpd_pkg::CHAR_STAR) begin
               scan_phase = SCAN_COUNT;
            end else begin
               held_char = c;
               held_ok = 1'b1;
               r.payload_char = c;
               r.repeat_count = 8'd1;
               decoded_due.push_back(r);
            end
         end
      end else begin
         scan_phase = SCAN_IDLE;
      end
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Queues one framed packet; the checksum is right, off by a nonzero amount, or carries
   // a character that is not a hex digit.
   task automatic queue_frame(input byte_queue_type body, input ck_mode_type mode);
      logic [7:0] sum;
      logic [7:0] c;
      logic [7:0] digit[2];
      logic [4:0] d;
      sum = 8'h00;
      foreach (body[i]) sum = sum + body[i];
      if (mode == CK_WRONG) sum = sum + 8'($urandom_range(255, 1));
      digit[0] = hex_char(sum[7:4], 1'($urandom_range(1)));
      digit[1] = hex_char(sum[3:0], 1'($urandom_range(1)));
      if (mode == CK_BADHEX) begin
         c = 8'($urandom_range(255));
         d = hex_digit(c);
         while (d[4]) begin
            c = 8'($urandom_range(255));
            d = hex_digit(c);
         end
         digit[1'($urandom_range(1))] = c;
      end
      rx_backlog.push_back(dpd_pkg::CHAR_DOLLAR);
      foreach (body[i]) rx_backlog.push_back(body[i]);
      rx_backlog.push_back(dpd_pkg::CHAR_HASH);
      rx_backlog.push_back(digit[0]);
      rx_backlog.push_back(digit[1]);
      queued_bytes += body.size() + 3;
   endtask

   task automatic random_frame();
      byte_queue_type body;
      int             len;
      int             pick;
      logic [7:0]     c;
      ck_mode_type    mode;
      len = ($urandom_range(24) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
      while (body.size() < len) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            body.push_back(8'($urandom_range(8'h7A, 8'h61)));
         end else if (pick < 60) begin
            c = 8'($urandom_range(255));
            while (c == dpd_pkg::CHAR_DOLLAR || c == dpd_pkg::CHAR_HASH)
               c = 8'($urandom_range(255));
            body.push_back(c);
         end else if (pick < 75) begin
            case ($urandom_range(2))
               0: body.push_back(dpd_pkg::CHAR_COMMA);
               1: body.push_back(dpd_pkg::CHAR_SEMI);
               default: body.push_back(dpd_pkg::CHAR_COLON);
            endcase
         end else begin
            // Run marker with a count that mostly expands, sometimes not.
            body.push_back(dpd_pkg::CHAR_STAR);
            c = ($urandom_range(4) == 0) ? 8'($urandom_range(29)) : 8'($urandom_range(255, 30));
            while (c == dpd_pkg::CHAR_DOLLAR || c == dpd_pkg::CHAR_HASH)
               c = 8'($urandom_range(255));
            body.push_back(c);
         end
      end
      // A trailing run marker puts the end marker where the count belongs.
      if ($urandom_range(19) == 0) body.push_back(dpd_pkg::CHAR_STAR);
      pick = $urandom_range(99);
      mode = (pick < 70) ? CK_GOOD : (pick < 85) ? CK_WRONG : CK_BADHEX;
      queue_frame(body, mode);
   endtask

   // Mostly well-formed packets, with line noise and cut-off packets in between.
   task automatic random_traffic(input int budget);
      int first;
      int pick;
      first = queued_bytes;
      while (queued_bytes - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(4, 1)) rx_backlog.push_back(8'($urandom_range(255)));
         end else if (pick < 18) begin
            rx_backlog.push_back(dpd_pkg::CHAR_DOLLAR);
            repeat ($urandom_range(6, 1)) rx_backlog.push_back(8'($urandom_range(255)));
         end
         random_frame();
      end
   endtask

   // Checked at the rising edge, where the offered byte and both queues are settled.
   task automatic wait_drained();
      while (rx_backlog.size() != 0 || req_valid || decoded_due.size() != 0)
         @(posedge clock);
   endtask

   // Input side: a new byte is offered only once the previous one has been transferred.
   always @(posedge clock) begin
      byte_taken = !reset && req_valid && !req_stall;
      if (byte_taken) begin
         parse_rx_byte(req_rx_byte);
         bytes_taken++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output side stall, with a long hold-off, counted here, whenever hold_seq is bumped.
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      deframed_type got;
      deframed_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_payload_char, rsp_repeat_count, rsp_field_end, rsp_packet_end,
                rsp_checksum_ok};
         results_seen++;
         if (got.packet_end) begin
            if (got.checksum_ok) ack_count++;
            else nak_count++;
         end
         if (got.repeat_count > 8'd1) run_count++;
         if (decoded_due.size() == 0) begin
            report_error($sformatf("unexpected result char %h count %0d fe %b pe %b ok %b",
               got.payload_char, got.repeat_count, got.field_end, got.packet_end,
               got.checksum_ok));
         end else begin
            want = decoded_due.pop_front();
            if (got != want)
               report_error($sformatf({"result %0d: expected char %h count %0d fe %b pe %b ",
                  "ok %b, got char %h count %0d fe %b pe %b ok %b"}, results_seen,
                  want.payload_char, want.repeat_count, want.field_end, want.packet_end,
                  want.checksum_ok, got.payload_char, got.repeat_count, got.field_end,
                  got.packet_end, got.checksum_ok));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      byte_queue_type frame_a;
      byte_queue_type oddities;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 37;
      recv_idle_pct = 81;

      // Idle bytes at both extremes, then a good packet with runs that expand, runs after a
      // delimiter that have nothing held, counts at and just past the bias, and 00/FF data.
      rx_backlog.push_back(8'h00);
      rx_backlog.push_back(8'hFF);
      frame_a = '{8'h61, dpd_pkg::CHAR_STAR, 8'hFF, dpd_pkg::CHAR_COMMA, dpd_pkg::CHAR_STAR,
                  8'h5A, dpd_pkg::CHAR_SEMI, 8'h62, dpd_pkg::CHAR_STAR, 8'd29,
                  dpd_pkg::CHAR_STAR, 8'd30, dpd_pkg::CHAR_COLON, 8'h00, 8'hFF};
      queue_frame(frame_a, CK_GOOD);
      // Restart inside the payload and inside a count, an end marker in the count position,
      // then a start marker and a non-hex letter taking the checksum positions.
      oddities = '{dpd_pkg::CHAR_DOLLAR, 8'h71, dpd_pkg::CHAR_DOLLAR, dpd_pkg::CHAR_STAR,
                   dpd_pkg::CHAR_DOLLAR, dpd_pkg::CHAR_STAR, dpd_pkg::CHAR_HASH,
                   dpd_pkg::CHAR_DOLLAR, 8'h67};
      foreach (oddities[i]) rx_backlog.push_back(oddities[i]);
      wait_drained();

      // Long output hold-off while bytes keep coming, so the block backs up.
      @(posedge clock);
      hold_seq++;
      random_traffic(80);
      wait_drained();

      @(posedge clock);
      random_traffic(320);
      wait_drained();

      @(posedge clock);
      send_idle_pct = 81;
      recv_idle_pct = 37;
      random_traffic(320);
      wait_drained();

      @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(320);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (decoded_due.size() != 0)
         report_error($sformatf("%0d expected results never arrived", decoded_due.size()));
      $display("Sent %0d bytes and checked %0d results: %0d packets acked, %0d rejected,",
               bytes_taken, results_seen, ack_count, nak_count);
      $display("%0d runs; traffic ran sender-heavy, receiver-heavy, unthrottled and held off.",
               run_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
